// ----- rtl/buddy_page_allocator_assert.svh -----
// Assertion macros shared by the allocator modules.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpa check failed");

// Next-cycle implication, checked out of reset.
`define BPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpa check failed");

`endif

// ----- rtl/bpa_pkg.sv -----
package bpa_pkg;

  localparam int unsigned FRAME_W     = 12;
  localparam int unsigned ORDER_W     = 4;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned LINK_W      = FRAME_W + 1;  // null flag on top
  localparam int unsigned PAGE_FRAMES = 4096;
  localparam int unsigned TOP_ORDER   = 10;

  localparam logic [LINK_W-1:0] NULL_LINK = {1'b1, {FRAME_W{1'b0}}};

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic               command;
    logic [ORDER_W-1:0] block_order;
    logic [FRAME_W-1:0] frame_in;
  } bpa_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic               granted;
    logic [COUNT_W-1:0] pages_free;
  } bpa_rsp_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_UP,
    OP_POP_RD,
    OP_POP_WR,
    OP_SPLIT,
    OP_ALLOC_DONE,
    OP_WALK_INIT,
    OP_WALK_RD,
    OP_WALK_ADV,
    OP_HIT_RD,
    OP_UNLINK,
    OP_FREE_PUSH
  } bpa_op_e;

  typedef struct packed {
    logic in_bad;      // incoming word is rejected outright
    logic in_free;     // incoming word is a free
    logic head_null;   // list at current level is empty
    logic lvl_top;     // current level is the top order
    logic lvl_gt_ord;  // splits still to do
    logic cur_null;    // walk reached list end
    logic cur_hit;     // walk found the buddy
    logic steps_max;   // walk bound reached
  } bpa_sts_t;

endpackage

// ----- rtl/buddy_page_allocator.sv -----
// Binary buddy page allocator over 4096 page frames, orders 0 to 10, blocks
// named by first frame number. Raise start with a request word while busy is
// low; the word is taken at that edge and busy stays high until the result.
// The result word appears on rsp_o for exactly one cycle with done_o high;
// the receiver cannot stall it, so it must sample on that cycle. Every request
// gets one result. An allocate scans upward past empty orders, pops the head
// of the first non-empty list and splits down to the requested order; a free
// walks the free list at each level for the buddy, unlinks it and merges up,
// then pushes the block. Each step of a free-list walk is a registered read
// of the per-frame link memory (one read and one write port). A rejected
// request (order above 10, or a misaligned or overhanging free) answers with
// granted 0. Double frees are not caught; each list walk is capped at 4096
// steps. No clearing pass: links are only read after they are written.
module buddy_page_allocator import bpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  bpa_req_t req_i,
  output logic     done_o,
  output bpa_rsp_t rsp_o
);

  bpa_op_e  op;
  bpa_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .op_o    (op),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  bpa_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .req_i  (req_i),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- rtl/bpa_ctrl.sv -----
module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  bpa_sts_t sts_i,
  output bpa_op_e  op_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_POP, S_SPLIT, S_WALK_INIT, S_WALK, S_NEXT, S_UNLINK,
    S_PUSH, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_o = OP_LOAD;
          if (sts_i.in_bad) state_d = S_DONE;
          else if (sts_i.in_free) state_d = S_WALK_INIT;
          else state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.head_null) begin
          op_o    = OP_POP_RD;
          state_d = S_POP;
        end else if (sts_i.lvl_top) begin
          state_d = S_DONE;
        end else begin
          op_o = OP_SCAN_UP;
        end
      end
      S_POP: begin
        op_o    = OP_POP_WR;
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        if (sts_i.lvl_gt_ord) begin
          op_o = OP_SPLIT;
        end else begin
          op_o    = OP_ALLOC_DONE;
          state_d = S_DONE;
        end
      end
      S_WALK_INIT: begin
        if (sts_i.lvl_top) begin
          state_d = S_PUSH;
        end else begin
          op_o    = OP_WALK_INIT;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.cur_null || sts_i.steps_max) begin
          state_d = S_PUSH;
        end else if (sts_i.cur_hit) begin
          op_o    = OP_HIT_RD;
          state_d = S_UNLINK;
        end else begin
          op_o    = OP_WALK_RD;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        op_o    = OP_WALK_ADV;
        state_d = S_WALK;
      end
      S_UNLINK: begin
        op_o    = OP_UNLINK;
        state_d = S_WALK_INIT;
      end
      S_PUSH: begin
        op_o    = OP_FREE_PUSH;
        state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

`include "buddy_page_allocator_assert.svh"
  `BPA_ASSERT_NXT(a_done_then_idle, done_o, !busy_o)
  `BPA_ASSERT_NXT(a_start_goes_busy, start_i && !busy_o, busy_o)
  `BPA_ASSERT_NOW(a_no_op_when_done, done_o, op_o == OP_NONE)

endmodule

// ----- rtl/bpa_dp.sv -----
module bpa_dp import bpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bpa_op_e  op_i,
  input  bpa_req_t req_i,
  output bpa_sts_t sts_o,
  output bpa_rsp_t rsp_o
);

  logic [LINK_W-1:0]  link_mem [PAGE_FRAMES];
  logic [LINK_W-1:0]  rdata_q;
  logic [LINK_W-1:0]  heads_q [TOP_ORDER+1];

  logic               cmd_q;
  logic [ORDER_W-1:0] ord_q, lvl_q;
  logic [FRAME_W-1:0] blk_q;
  logic [LINK_W-1:0]  cur_q, prev_q;
  logic [COUNT_W-1:0] steps_q, count_q;
  logic [FRAME_W-1:0] res_frame_q;
  logic               res_ok_q;

  logic               we;
  logic [FRAME_W-1:0] waddr, raddr;
  logic [LINK_W-1:0]  wdata;

  logic [ORDER_W-1:0] lvl_m1;
  logic [FRAME_W-1:0] lvl_bit, half, split_frame, target;
  logic [COUNT_W-1:0] in_size, ord_size;
  logic [COUNT_W:0]   count_sum;

  assign lvl_m1      = lvl_q - ORDER_W'(1);
  assign lvl_bit     = FRAME_W'(1) << lvl_q;
  assign half        = FRAME_W'(1) << lvl_m1;
  assign split_frame = blk_q + half;
  assign target      = blk_q ^ lvl_bit;
  assign in_size     = COUNT_W'(1) << req_i.block_order;
  assign ord_size    = COUNT_W'(1) << ord_q;
  assign count_sum   = {1'b0, count_q} + {1'b0, ord_size};

  // rejection: order too big, or a misaligned / overhanging free
  always_comb begin
    sts_o.in_free = (req_i.command == CMD_FREE);
    sts_o.in_bad  = (req_i.block_order > ORDER_W'(TOP_ORDER)) ||
                    (sts_o.in_free &&
                     (((COUNT_W'(req_i.frame_in) & (in_size - COUNT_W'(1))) != '0) ||
                      ((COUNT_W'(req_i.frame_in) + in_size) > COUNT_W'(PAGE_FRAMES))));
    sts_o.head_null  = heads_q[lvl_q][LINK_W-1];
    sts_o.lvl_top    = (lvl_q == ORDER_W'(TOP_ORDER));
    sts_o.lvl_gt_ord = (lvl_q > ord_q);
    sts_o.cur_null   = cur_q[LINK_W-1];
    sts_o.cur_hit    = !cur_q[LINK_W-1] && (cur_q[FRAME_W-1:0] == target);
    sts_o.steps_max  = (steps_q == COUNT_W'(PAGE_FRAMES));
  end

  // link memory port controls
  always_comb begin
    we    = 1'b0;
    waddr = blk_q;
    wdata = heads_q[lvl_q];
    raddr = cur_q[FRAME_W-1:0];
    case (op_i)
      OP_POP_RD: raddr = heads_q[lvl_q][FRAME_W-1:0];
      OP_SPLIT: begin
        we    = 1'b1;
        waddr = split_frame;
        wdata = heads_q[lvl_m1];
      end
      OP_UNLINK: begin
        we    = !prev_q[LINK_W-1];
        waddr = prev_q[FRAME_W-1:0];
        wdata = rdata_q;
      end
      OP_FREE_PUSH: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) link_mem[waddr] <= wdata;
    rdata_q <= link_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= TOP_ORDER; i++) heads_q[i] <= NULL_LINK;
      count_q     <= '0;
      res_ok_q    <= 1'b0;
      res_frame_q <= '0;
      cmd_q       <= CMD_ALLOC;
      ord_q       <= '0;
      lvl_q       <= '0;
      blk_q       <= '0;
      cur_q       <= NULL_LINK;
      prev_q      <= NULL_LINK;
      steps_q     <= '0;
    end else begin
      case (op_i)
        OP_LOAD: begin
          cmd_q       <= req_i.command;
          ord_q       <= req_i.block_order;
          lvl_q       <= req_i.block_order;
          blk_q       <= req_i.frame_in;
          res_ok_q    <= 1'b0;
          res_frame_q <= '0;
        end
        OP_SCAN_UP: lvl_q <= lvl_q + ORDER_W'(1);
        OP_POP_RD:  blk_q <= heads_q[lvl_q][FRAME_W-1:0];
        OP_POP_WR:  heads_q[lvl_q] <= rdata_q;
        OP_SPLIT: begin
          heads_q[lvl_m1] <= {1'b0, split_frame};
          lvl_q           <= lvl_m1;
        end
        OP_ALLOC_DONE: begin
          count_q     <= (count_q > ord_size) ? count_q - ord_size : '0;
          res_frame_q <= blk_q;
          res_ok_q    <= 1'b1;
        end
        OP_WALK_INIT: begin
          cur_q   <= heads_q[lvl_q];
          prev_q  <= NULL_LINK;
          steps_q <= '0;
        end
        OP_WALK_RD: begin
          prev_q  <= cur_q;
          steps_q <= steps_q + COUNT_W'(1);
        end
        OP_WALK_ADV: cur_q <= rdata_q;
        OP_UNLINK: begin
          if (prev_q[LINK_W-1]) heads_q[lvl_q] <= rdata_q;
          blk_q <= blk_q & ~lvl_bit;
          lvl_q <= lvl_q + ORDER_W'(1);
        end
        OP_FREE_PUSH: begin
          heads_q[lvl_q] <= {1'b0, blk_q};
          count_q  <= (count_sum > (COUNT_W+1)'(PAGE_FRAMES)) ?
                      COUNT_W'(PAGE_FRAMES) : count_sum[COUNT_W-1:0];
          res_ok_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign rsp_o.frame_out  = res_frame_q;
  assign rsp_o.granted    = res_ok_q;
  assign rsp_o.pages_free = count_q;

`include "buddy_page_allocator_assert.svh"
  `BPA_ASSERT_NOW(a_count_bounded, 1'b1, count_q <= COUNT_W'(PAGE_FRAMES))
  `BPA_ASSERT_NOW(a_free_no_frame, res_ok_q && cmd_q == CMD_FREE, res_frame_q == '0)

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

// Testbench for buddy_page_allocator.
// The stimulus is built up front. Each word is run through a local copy of the
// allocator state as it is generated, so the expected response is known at
// once. This also lets the random part free the blocks that were really
// handed out. The driver replays the queued words in bursts with random gaps.
// The monitor samples every done_o strobe and compares it with the oldest
// expected response.
module tb;
  import bpa_pkg::*;

  localparam int unsigned NO_FRAME  = 32'hFFFF_FFFF;
  localparam int          N_RANDOM  = 700;

  // a block currently handed out, as seen by the local allocator copy
  typedef struct {
    int unsigned frame;
    int unsigned order;
  } held_blk_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  bpa_req_t req_i;
  logic     done_o;
  bpa_rsp_t rsp_o;

  // local allocator state
  int unsigned free_head[0:TOP_ORDER];
  int unsigned frame_link[0:PAGE_FRAMES-1];
  int unsigned page_cnt;

  bpa_req_t  req_pending_q[$];    // words still to be driven
  bit        drain_first_q[$];    // driver waits for all responses first
  bpa_rsp_t  expected_rsp_q[$];   // responses in issue order
  held_blk_t held_q[$];

  int n_words;                    // words generated
  int n_sent;                     // words taken by the DUT
  int n_rsp;                      // responses seen
  int n_fail;
  int n_grant_alloc, n_grant_free, n_reject;
  bit gen_done;

  buddy_page_allocator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Local allocator: LIFO free list per order, links kept per frame.
  // ---------------------------------------------------------------------------
  function automatic void push_free(int unsigned ord, int unsigned frm);
    if (ord > TOP_ORDER || frm >= PAGE_FRAMES) return;
    frame_link[frm] = free_head[ord];
    free_head[ord]  = frm;
  endfunction

  function automatic int unsigned pop_free(int unsigned ord);
    int unsigned h;
    if (ord > TOP_ORDER) return NO_FRAME;
    h = free_head[ord];
    if (h == NO_FRAME) return NO_FRAME;
    free_head[ord] = (h < PAGE_FRAMES) ? frame_link[h] : NO_FRAME;
    return h;
  endfunction

  // unlink the buddy from its list; walk is capped like the hardware's
  function automatic bit take_buddy(int unsigned ord, int unsigned tgt);
    int unsigned prv;
    int unsigned cur;
    int unsigned steps;
    prv = NO_FRAME;
    if (ord > TOP_ORDER) return 1'b0;
    cur = free_head[ord];
    for (steps = 0; steps < PAGE_FRAMES && cur < PAGE_FRAMES; steps++) begin
      if (cur == tgt) begin
        if (prv == NO_FRAME) free_head[ord] = frame_link[cur];
        else frame_link[prv] = frame_link[cur];
        return 1'b1;
      end
      prv = cur;
      cur = frame_link[cur];
    end
    return 1'b0;
  endfunction

  function automatic bpa_rsp_t predict_rsp(bpa_req_t w);
    bpa_rsp_t    r;
    int unsigned ord;
    int unsigned frm;
    int unsigned sz;
    int unsigned blk;
    int unsigned lvl;
    int unsigned piv;
    int unsigned i;
    ord = w.block_order;
    frm = w.frame_in;
    r.frame_out = '0;
    r.granted   = 1'b0;
    if (ord <= TOP_ORDER) begin
      sz = 1 << ord;
      if (w.command == CMD_ALLOC) begin
        for (i = ord; i <= TOP_ORDER; i++) begin
          blk = pop_free(i);
          if (blk != NO_FRAME) begin
            // hand back upper halves down to the requested order
            while (i > ord) begin
              i--;
              push_free(i, blk + (1 << i));
            end
            page_cnt    = (page_cnt > sz) ? page_cnt - sz : 0;
            r.frame_out = blk[FRAME_W-1:0];
            r.granted   = 1'b1;
            break;
          end
        end
      end else if ((frm & (sz - 1)) == 0 && frm + sz <= PAGE_FRAMES) begin
        lvl = ord;
        piv = frm;
        while (lvl < TOP_ORDER && take_buddy(lvl, piv ^ (1 << lvl))) begin
          piv &= ~(1 << lvl);
          lvl++;
        end
        push_free(lvl, piv);
        page_cnt += sz;
        if (page_cnt > PAGE_FRAMES) page_cnt = PAGE_FRAMES;
        r.granted = 1'b1;
      end
    end
    r.pages_free = page_cnt[COUNT_W-1:0];
    return r;
  endfunction

  // queue one word, predict it and track handed-out blocks
  task automatic add_word(logic cmd, int unsigned ord, int unsigned frm, bit drain);
    bpa_req_t w;
    bpa_rsp_t r;
    w.command     = cmd;
    w.block_order = ord[ORDER_W-1:0];
    w.frame_in    = frm[FRAME_W-1:0];
    r = predict_rsp(w);
    if (cmd == CMD_ALLOC && r.granted) held_q.push_back('{r.frame_out, ord});
    if (!r.granted) n_reject++;
    else if (cmd == CMD_ALLOC) n_grant_alloc++;
    else n_grant_free++;
    req_pending_q.push_back(w);
    drain_first_q.push_back(drain);
    expected_rsp_q.push_back(r);
    n_words++;
  endtask

  task automatic free_held(int idx, bit drain);
    held_blk_t b;
    b = held_q[idx];
    held_q.delete(idx);
    add_word(CMD_FREE, b.order, b.frame, drain);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned ord;
    int unsigned sel;
    for (int i = 0; i <= TOP_ORDER; i++) free_head[i] = NO_FRAME;
    foreach (frame_link[i]) frame_link[i] = 0;
    page_cnt = 0;
    gen_done = 1'b0;

    // directed: empty pool, loading, rejects, extremes of order
    add_word(CMD_ALLOC, 0, 12'hFFF, 0);           // nothing free yet
    add_word(CMD_FREE, 10, 0, 0);
    add_word(CMD_FREE, 10, 1024, 0);
    add_word(CMD_FREE, 10, 2048, 0);
    add_word(CMD_FREE, 10, 3072, 0);              // whole pool free
    add_word(CMD_FREE, 11, 0, 0);                 // order too high, ignored
    add_word(CMD_FREE, 15, 12'hFFF, 0);
    add_word(CMD_ALLOC, 15, 0, 0);                // order too high, fails
    add_word(CMD_FREE, 3, 5, 0);                  // misaligned
    add_word(CMD_FREE, 10, 512, 0);               // misaligned at top order
    add_word(CMD_ALLOC, 0, 0, 0);                 // splits all the way down
    add_word(CMD_ALLOC, 0, 0, 0);
    add_word(CMD_ALLOC, 10, 0, 0);
    add_word(CMD_ALLOC, 5, 0, 1);
    add_word(CMD_ALLOC, 10, 0, 0);
    add_word(CMD_ALLOC, 10, 0, 0);
    add_word(CMD_ALLOC, 10, 0, 0);                // none left at top order
    while (held_q.size() > 0) free_held(held_q.size() - 1, 0);  // merge back
    add_word(CMD_ALLOC, 10, 0, 1);

    // random: mostly alloc / free of real blocks, some rejected noise
    for (int n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(99);
      if (sel < 45 || held_q.size() == 0) begin
        case ($urandom_range(9))
          0:       ord = $urandom_range(15);
          1, 2:    ord = $urandom_range(TOP_ORDER);
          default: ord = $urandom_range(4);
        endcase
        add_word(CMD_ALLOC, ord, $urandom_range(4095), $urandom_range(49) == 0);
      end else if (sel < 92) begin
        free_held($urandom_range(held_q.size() - 1), $urandom_range(49) == 0);
      end else if (sel < 96) begin
        add_word(CMD_FREE, $urandom_range(15, TOP_ORDER + 1), $urandom_range(4095), 0);
      end else begin
        ord = $urandom_range(TOP_ORDER, 1);
        add_word(CMD_FREE, ord, ($urandom_range(4095) & ~((1 << ord) - 1)) | 1, 0);
      end
    end

    // give everything back, then double free: count saturates at the top
    while (held_q.size() > 0) free_held($urandom_range(held_q.size() - 1), 0);
    add_word(CMD_FREE, 10, 0, 1);
    add_word(CMD_FREE, 0, 4095, 0);
    add_word(CMD_ALLOC, 0, 0, 0);
    add_word(CMD_ALLOC, 10, 0, 0);
    gen_done = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts with random gaps; a drain word waits for all responses.
  // ---------------------------------------------------------------------------
  int burst_left, gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    bit took;
    bit quiet;
    if (!rst_ni) begin
      start      <= 1'b0;
      req_i      <= '0;
      burst_left <= 0;
      gap_left   <= 0;
      n_sent     <= 0;
    end else begin
      took  = start && !busy;
      quiet = (n_sent + took) == (n_rsp + done_o);
      if (took) n_sent <= n_sent + 1;
      if (start && busy) begin
        // hold the current word
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_pending_q.size() > 0 && (!drain_first_q[0] || quiet)) begin
        start <= 1'b1;
        req_i <= req_pending_q.pop_front();
        void'(drain_first_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: one response per strobe, checked in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    bpa_rsp_t exp_r;
    if (!rst_ni) begin
      n_rsp <= 0;
    end else if (done_o) begin
      n_rsp <= n_rsp + 1;
      if (expected_rsp_q.size() == 0) begin
        $error("response with nothing outstanding: %p", rsp_o);
        n_fail++;
      end else begin
        exp_r = expected_rsp_q.pop_front();
        if (rsp_o.frame_out !== exp_r.frame_out) begin
          $error("frame_out expected %0d actual %0d", exp_r.frame_out, rsp_o.frame_out);
          n_fail++;
        end
        if (rsp_o.granted !== exp_r.granted) begin
          $error("granted expected %0d actual %0d", exp_r.granted, rsp_o.granted);
          n_fail++;
        end
        if (rsp_o.pages_free !== exp_r.pages_free) begin
          $error("pages_free expected %0d actual %0d", exp_r.pages_free,
                 rsp_o.pages_free);
          n_fail++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reset, end of run
  // ---------------------------------------------------------------------------
  initial begin
    n_fail = 0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (gen_done);
    while (req_pending_q.size() > 0 || start || n_rsp < n_words) @(posedge clk_i);
    repeat (100) @(posedge clk_i);   // catch any stray response
    if (expected_rsp_q.size() != 0) begin
      $error("%0d responses never arrived", expected_rsp_q.size());
      n_fail++;
    end
    $display("Ran %0d words: %0d allocs granted, %0d frees done, %0d rejected,",
             n_words, n_grant_alloc, n_grant_free, n_reject);
    $display("including empty pool, bad orders, misaligned and double frees.");
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
